/* src/rau_pkg.sv */
// Package with the shared types, command codes and width constants of the rational unit.
package rau_pkg;

    localparam int OperandBitsDefault = 16;
    localparam int CmdBits = 3;
    localparam int NumOutBits = 33;
    localparam int DenOutBits = 31;
    // Magnitudes of products of two operands fit in this many bits (sum adds one).
    localparam int MagBits = 2 * 31 + 1;

    typedef enum logic [CmdBits-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MIN = 3'd4,
        CMD_MAX = 3'd5,
        CMD_NOP6 = 3'd6,
        CMD_NOP7 = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_DONE
    } bk_state_t;

endpackage

/* src/rau_front.sv */
// Front end: accepts words, flags error words and packs them for the queue.
module rau_front import rau_pkg::*; #(
    parameter int OPERAND_BITS = OperandBitsDefault
) (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [CmdBits-1:0]             s_command,
    input  logic signed [OPERAND_BITS-1:0] s_first_numerator,
    input  logic signed [OPERAND_BITS-1:0] s_first_denominator,
    input  logic signed [OPERAND_BITS-1:0] s_second_numerator,
    input  logic signed [OPERAND_BITS-1:0] s_second_denominator,
    // Queue write side.
    output logic                           q_wr,
    input  logic                           q_full,
    output logic [CmdBits+1+4*OPERAND_BITS-1:0] q_data
);

    logic bad;

    // A word is an error when a denominator is zero or a division has a zero divisor.
    always_comb begin
        bad = (s_first_denominator == '0) || (s_second_denominator == '0) ||
              ((cmd_t'(s_command) == CMD_DIV) && (s_second_numerator == '0));
    end

    assign s_ready = !q_full;
    assign q_wr = s_valid && !q_full;
    assign q_data = {s_command, bad, s_first_numerator, s_first_denominator,
                     s_second_numerator, s_second_denominator};

endmodule

/* src/rau_queue.sv */
// Two-entry queue that decouples the front end from the back end.
module rau_queue import rau_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    // Storage is written without reset; pointers and count are cleared.
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) begin
                wp_reg <= !wp_reg;
            end
            if (rd) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) full |-> !wr;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge aclk) disable iff (!aresetn) empty |-> !rd;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

    property p_count_range;
        @(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3;
    endproperty
    a_count_range: assert property (p_count_range) else $error("queue count broken");

endmodule

/* src/rau_back.sv */
// Back end: forms cross products, runs Euclid and divides out the common factor.
module rau_back import rau_pkg::*; #(
    parameter int OPERAND_BITS = OperandBitsDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    output logic                           q_rd,
    input  logic [CmdBits+1+4*OPERAND_BITS-1:0] q_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [NumOutBits-1:0]   m_result_numerator,
    output logic [DenOutBits-1:0]          m_result_denominator,
    output logic                           m_zero_divide
);

    localparam int OB = OPERAND_BITS;
    localparam int PB = 2 * OB;          // signed product width
    localparam int MB = 2 * OB + 1;      // magnitude width incl. sum growth
    localparam int CB = $clog2(MB + 1);

    bk_state_t state_reg, state_next;

    logic signed [OB-1:0] a_reg, b_reg, c_reg, d_reg;
    cmd_t                 cmd_reg;
    logic signed [PB-1:0] p0_reg, p1_reg, p2_reg;
    logic                 neg_reg;
    logic [MB-1:0]        un_reg, ud_reg, x_reg, y_reg;
    // Restoring divider state.
    logic [MB-1:0]        quo_reg, rem_reg, dvs_reg;
    logic [CB-1:0]        cnt_reg;
    logic                 gcd_mod_reg;
    // Working result, copied to the output register when it is free.
    logic signed [NumOutBits-1:0] wn_reg;
    logic [DenOutBits-1:0] wd_reg;
    logic                 bad_reg;
    logic signed [NumOutBits-1:0] rn_reg;
    logic [DenOutBits-1:0] rd_reg;
    logic                 zd_reg, ov_reg;

    logic [CmdBits-1:0]   q_cmd;
    logic                 q_bad;
    logic signed [OB-1:0] qa, qb, qc, qd;
    logic signed [PB-1:0] qa_w, qb_w, qc_w, qd_w;
    logic signed [PB:0]   n_sum;
    logic signed [PB-1:0] den_s;
    logic                 pick_first;
    logic [MB:0]          rem_sh;
    logic [MB-1:0]        rem_new, num_mag;

    assign {q_cmd, q_bad, qa, qb, qc, qd} = q_data;

    // Operands widened to product width before multiplying.
    assign qa_w = PB'(qa);
    assign qb_w = PB'(qb);
    assign qc_w = PB'(qc);
    assign qd_w = PB'(qd);

    // A word is taken from the queue when the sequencer is idle and the queue is not empty.
    assign q_rd = (state_reg == BK_IDLE) && !q_empty;

    assign m_valid = ov_reg;
    assign m_result_numerator = rn_reg;
    assign m_result_denominator = rd_reg;
    assign m_zero_divide = zd_reg;

    // Numerator and denominator selection from the registered products.
    always_comb begin
        n_sum = '0;
        den_s = p2_reg;
        pick_first = 1'b0;
        case (cmd_reg)
            CMD_ADD: n_sum = {p0_reg[PB-1], p0_reg} + {p1_reg[PB-1], p1_reg};
            CMD_SUB: n_sum = {p0_reg[PB-1], p0_reg} - {p1_reg[PB-1], p1_reg};
            CMD_MUL: n_sum = {p0_reg[PB-1], p0_reg};
            CMD_DIV: n_sum = {p0_reg[PB-1], p0_reg};
            CMD_MIN, CMD_MAX: begin
                // Sign fix: the comparison flips when exactly one denominator is negative.
                pick_first = (b_reg[OB-1] ^ d_reg[OB-1]) ?
                             ((cmd_reg == CMD_MIN) ? (p0_reg > p1_reg) : (p0_reg < p1_reg)) :
                             ((cmd_reg == CMD_MIN) ? (p0_reg < p1_reg) : (p0_reg > p1_reg));
                n_sum = pick_first ? (PB+1)'(a_reg) : (PB+1)'(c_reg);
                den_s = pick_first ? PB'(b_reg) : PB'(d_reg);
            end
            default: begin
                // Unused commands give zero over one.
                n_sum = '0;
                den_s = PB'(1);
            end
        endcase
        num_mag = n_sum[PB] ? MB'(-n_sum) : MB'(n_sum);
    end

    // One restoring division step per cycle.
    always_comb begin
        rem_sh = {rem_reg, quo_reg[MB-1]};
        rem_new = rem_sh[MB-1:0];
        if (rem_sh >= {1'b0, dvs_reg}) begin
            rem_new = MB'(rem_sh - {1'b0, dvs_reg});
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_rd) state_next = q_bad ? BK_DONE : BK_MUL;
            BK_MUL: state_next = BK_GCD;
            BK_GCD: if (!gcd_mod_reg && y_reg == '0) state_next = BK_DIVN;
            BK_DIVN: if (cnt_reg == CB'(MB)) state_next = BK_DIVD;
            BK_DIVD: if (cnt_reg == CB'(MB)) state_next = BK_DONE;
            BK_DONE: if (!ov_reg || m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            ov_reg <= 1'b0;
            gcd_mod_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // The output register fills from the working result and empties when taken.
            if ((state_reg == BK_DONE) && (!ov_reg || m_ready)) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE: begin
                    if (q_rd) begin
                        cmd_reg <= cmd_t'(q_cmd);
                        a_reg <= qa;
                        b_reg <= qb;
                        c_reg <= qc;
                        d_reg <= qd;
                        bad_reg <= q_bad;
                        wn_reg <= '0;
                        wd_reg <= DenOutBits'(1);
                        // Products: a*d (a*c for multiply), c*b, and the denominator product.
                        p0_reg <= (cmd_t'(q_cmd) == CMD_MUL) ? qa_w * qc_w : qa_w * qd_w;
                        p1_reg <= qc_w * qb_w;
                        p2_reg <= (cmd_t'(q_cmd) == CMD_DIV) ? qb_w * qc_w : qb_w * qd_w;
                    end
                end
                BK_MUL: begin
                    un_reg <= num_mag;
                    ud_reg <= den_s[PB-1] ? MB'(-den_s) : MB'(den_s);
                    neg_reg <= n_sum[PB] ^ den_s[PB-1];
                    x_reg <= num_mag;
                    y_reg <= den_s[PB-1] ? MB'(-den_s) : MB'(den_s);
                    gcd_mod_reg <= 1'b0;
                end
                BK_GCD: begin
                    // Each Euclid step is a full iterative remainder.
                    if (!gcd_mod_reg) begin
                        if (y_reg != '0) begin
                            quo_reg <= x_reg;
                            rem_reg <= '0;
                            dvs_reg <= y_reg;
                            cnt_reg <= '0;
                            gcd_mod_reg <= 1'b1;
                        end else begin
                            quo_reg <= un_reg;
                            rem_reg <= '0;
                            dvs_reg <= x_reg;
                            cnt_reg <= '0;
                        end
                    end else begin
                        quo_reg <= {quo_reg[MB-2:0], 1'b0};
                        rem_reg <= rem_new;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CB'(MB - 1)) begin
                            x_reg <= y_reg;
                            y_reg <= rem_new;
                            gcd_mod_reg <= 1'b0;
                        end
                    end
                end
                BK_DIVN: begin
                    if (cnt_reg == CB'(MB)) begin
                        un_reg <= quo_reg;
                        quo_reg <= ud_reg;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                    end else begin
                        quo_reg <= {quo_reg[MB-2:0], rem_sh >= {1'b0, dvs_reg}};
                        rem_reg <= rem_new;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                BK_DIVD: begin
                    if (cnt_reg == CB'(MB)) begin
                        if (un_reg == '0) begin
                            wn_reg <= '0;
                            wd_reg <= DenOutBits'(1);
                        end else begin
                            wn_reg <= neg_reg ? NumOutBits'(-{1'b0, un_reg}) :
                                                NumOutBits'(un_reg);
                            wd_reg <= DenOutBits'(quo_reg);
                        end
                    end else begin
                        quo_reg <= {quo_reg[MB-2:0], rem_sh >= {1'b0, dvs_reg}};
                        rem_reg <= rem_new;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                BK_DONE: begin
                    if (!ov_reg || m_ready) begin
                        rn_reg <= wn_reg;
                        rd_reg <= wd_reg;
                        zd_reg <= bad_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    property p_single_take;
        @(posedge aclk) disable iff (!aresetn) q_rd |=> state_reg != BK_IDLE;
    endproperty
    a_single_take: assert property (p_single_take) else $error("back end took two words");

    property p_den_positive;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> m_result_denominator != '0;
    endproperty
    a_den_positive: assert property (p_den_positive) else $error("zero denominator out");

    property p_err_form;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_zero_divide) |-> (m_result_numerator == '0);
    endproperty
    a_err_form: assert property (p_err_form) else $error("error result not zero");

endmodule

/* src/rational_arithmetic_unit_top.sv */
// Top level of the rational arithmetic unit: front end, queue and back end.
//
//  Channel | Ports       | Direction | Contents
//  s_      | valid/ready | in        | command and two fractions
//  m_      | valid/ready | out       | reduced fraction and error flag
//
// The back end works on one word at a time; a single-bit restoring divider serves Euclid
// and both final divisions.
// Error words skip the products, Euclid and the divisions and go straight to the output.
// Reset is synchronous and active low and clears the queue and the sequencer.
// A two-word queue lets the front accept while the back end works or is stalled.
module rational_arithmetic_unit_top import rau_pkg::*; #(
    parameter int OPERAND_BITS = OperandBitsDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [CmdBits-1:0]             s_command,
    input  logic signed [OPERAND_BITS-1:0] s_first_numerator,
    input  logic signed [OPERAND_BITS-1:0] s_first_denominator,
    input  logic signed [OPERAND_BITS-1:0] s_second_numerator,
    input  logic signed [OPERAND_BITS-1:0] s_second_denominator,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [NumOutBits-1:0]   m_result_numerator,
    output logic [DenOutBits-1:0]          m_result_denominator,
    output logic                           m_zero_divide
);

    localparam int QW = CmdBits + 1 + 4 * OPERAND_BITS;

    logic          q_wr, q_full, q_rd, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .s_valid, .s_ready, .s_command,
        .s_first_numerator, .s_first_denominator,
        .s_second_numerator, .s_second_denominator,
        .q_wr, .q_full, .q_data(q_wdata)
    );

    rau_queue #(.WIDTH(QW)) u_queue (
        .aclk, .aresetn, .wr(q_wr), .wr_data(q_wdata), .full(q_full),
        .rd(q_rd), .empty(q_empty), .rd_data(q_rdata)
    );

    rau_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
        .aclk, .aresetn, .q_empty, .q_rd, .q_data(q_rdata),
        .m_valid, .m_ready, .m_result_numerator, .m_result_denominator, .m_zero_divide
    );

endmodule
